// ===== src/sgdm_pkg.sv =====
// Shared constants and saturating fixed-point helpers for the momentum SGD update block.
// Depends on nothing. Used by sgd_momentum_update.
package sgdm_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int COEF_WIDTH  = FRAC_BITS + 1;
   localparam int SCOEF_WIDTH = COEF_WIDTH + 1;
   localparam int PROD_WIDTH  = VALUE_WIDTH + SCOEF_WIDTH;
   localparam int PIPE_DEPTH  = 9;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [SCOEF_WIDTH-1:0] ONE_Q = SCOEF_WIDTH'(1) << FRAC_BITS;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic [COEF_WIDTH-1:0]         coef_type;
   typedef logic signed [SCOEF_WIDTH-1:0] scoef_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LEARNING_RATE   = 3'd0,
      CSR_MOMENTUM_FACTOR = 3'd1,
      CSR_DECAY_FACTOR    = 3'd2,
      CSR_DAMPING_FACTOR  = 3'd3,
      CSR_FIRST_STEP_MODE = 3'd4
   } csr_index_type;

   localparam value_type VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // Floor of the product over 2^FRAC_BITS, clamped to the value range.
   function automatic value_type sat_shift(input prod_type p);
      prod_type s;
      s = p >>> FRAC_BITS;
      if ((&s[PROD_WIDTH-1:VALUE_WIDTH-1]) || !(|s[PROD_WIDTH-1:VALUE_WIDTH-1])) begin
         return s[VALUE_WIDTH-1:0];
      end
      return p[PROD_WIDTH-1] ? VALUE_MIN : VALUE_MAX;
   endfunction

   function automatic value_type sat_add(input value_type a, input value_type b);
      logic signed [VALUE_WIDTH:0] s;
      s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
         return s[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX;
      end
      return s[VALUE_WIDTH-1:0];
   endfunction

   function automatic value_type sat_sub(input value_type a, input value_type b);
      logic signed [VALUE_WIDTH:0] s;
      s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
      if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
         return s[VALUE_WIDTH] ? VALUE_MIN : VALUE_MAX;
      end
      return s[VALUE_WIDTH-1:0];
   endfunction

endpackage

// ===== src/sgd_momentum_update.sv =====
// Momentum SGD update: one word accepted in every cycle, busy never rises.
// Each result is strobed on rsp_valid in the order in which its word was accepted.
// The three multiplier rows (decay, momentum and dampening, learning rate) set the depth.
// Reset clears the coefficient registers and the valid bits; words in flight are dropped.
// Depends on sgdm_pkg.
module sgd_momentum_update
   import sgdm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [VALUE_WIDTH-1:0] req_weight_value,
   input  logic signed [VALUE_WIDTH-1:0] req_gradient_value,
   input  logic signed [VALUE_WIDTH-1:0] req_old_velocity,
   output logic                       rsp_valid,
   output logic signed [VALUE_WIDTH-1:0] rsp_new_weight,
   output logic signed [VALUE_WIDTH-1:0] rsp_new_velocity,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COEF_WIDTH-1:0]      csr_wdata
);

   coef_type  lr_ff, mom_ff, decay_ff, damp_ff;
   logic      first_ff;
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic      accept;

   value_type w1_ff, g1_ff, vo1_ff;
   prod_type  pd1_ff, pd1_in;
   value_type w2_ff, g2_ff, vo2_ff, qd2_ff;
   value_type w3_ff, vo3_ff, g3_ff;
   value_type w4_ff, g4_ff;
   prod_type  pm4_ff, pk4_ff, pm4_in, pk4_in;
   value_type w5_ff, g5_ff, qm5_ff, qk5_ff;
   value_type w6_ff, v6_ff, v6_in;
   value_type w7_ff, v7_ff;
   prod_type  pl7_ff, pl7_in;
   value_type w8_ff, v8_ff, ql8_ff;
   value_type nw_ff, nv_ff;
   scoef_type keep, lr_s, mom_s, decay_s;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff    <= '0;
         mom_ff   <= '0;
         decay_ff <= '0;
         damp_ff  <= '0;
         first_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LEARNING_RATE:   lr_ff    <= csr_wdata;
            CSR_MOMENTUM_FACTOR: mom_ff   <= csr_wdata;
            CSR_DECAY_FACTOR:    decay_ff <= csr_wdata;
            CSR_DAMPING_FACTOR:  damp_ff  <= csr_wdata;
            CSR_FIRST_STEP_MODE: first_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      lr_s    = scoef_type'({1'b0, lr_ff});
      mom_s   = scoef_type'({1'b0, mom_ff});
      decay_s = scoef_type'({1'b0, decay_ff});
      keep    = scoef_type'(ONE_Q - {1'b0, damp_ff});
      pd1_in  = prod_type'(decay_s) * prod_type'(req_weight_value);
      pm4_in  = prod_type'(mom_s) * prod_type'(vo3_ff);
      pk4_in  = prod_type'(keep) * prod_type'(g3_ff);
      v6_in   = first_ff ? g5_ff : sat_add(qm5_ff, qk5_ff);
      pl7_in  = prod_type'(lr_s) * prod_type'(v6_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[PIPE_DEPTH-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      w1_ff  <= req_weight_value;
      g1_ff  <= req_gradient_value;
      vo1_ff <= req_old_velocity;
      pd1_ff <= pd1_in;

      w2_ff  <= w1_ff;
      g2_ff  <= g1_ff;
      vo2_ff <= vo1_ff;
      qd2_ff <= sat_shift(pd1_ff);

      w3_ff  <= w2_ff;
      vo3_ff <= vo2_ff;
      g3_ff  <= sat_add(g2_ff, qd2_ff);

      w4_ff  <= w3_ff;
      g4_ff  <= g3_ff;
      pm4_ff <= pm4_in;
      pk4_ff <= pk4_in;

      w5_ff  <= w4_ff;
      g5_ff  <= g4_ff;
      qm5_ff <= sat_shift(pm4_ff);
      qk5_ff <= sat_shift(pk4_ff);

      w6_ff  <= w5_ff;
      v6_ff  <= v6_in;

      w7_ff  <= w6_ff;
      v7_ff  <= v6_ff;
      pl7_ff <= pl7_in;

      w8_ff  <= w7_ff;
      v8_ff  <= v7_ff;
      ql8_ff <= sat_shift(pl7_ff);

      nw_ff  <= sat_sub(w8_ff, ql8_ff);
      nv_ff  <= v8_ff;
   end

   assign rsp_valid        = valid_ff[PIPE_DEPTH-1];
   assign rsp_new_weight   = nw_ff;
   assign rsp_new_velocity = nv_ff;

`ifndef SYNTHESIS
   // With no decay and the first-step mode set, the momentum is the raw gradient.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && first_ff && (decay_ff == '0)
      |-> rsp_new_velocity == $past(req_gradient_value, PIPE_DEPTH))
      else $error("first-step momentum differs from the incoming gradient");

   // A zero learning rate leaves the parameter unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (lr_ff == '0)
      |-> rsp_new_weight == $past(req_weight_value, PIPE_DEPTH))
      else $error("parameter changed under a zero learning rate");

   // The learning-rate step keeps the sign of a non-negative momentum.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] && !v7_ff[VALUE_WIDTH-1] |=> !ql8_ff[VALUE_WIDTH-1])
      else $error("learning-rate step turned negative for a non-negative momentum");
`endif

endmodule

// ===== sim/tb_sgd_momentum_update.sv =====
// Self-checking testbench for sgd_momentum_update: directed and random words over many settings.
// A scoreboard class predicts each update in fixed point and checks the strobed results in order.
// Depends on sgdm_pkg and sgd_momentum_update.
module tb_sgd_momentum_update
   import sgdm_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     STALL_LIMIT     = 2000;
   localparam int     RANDOM_PHASES   = 14;
   localparam int     WORDS_PER_PHASE = 125;
   localparam int     IDLE_PERCENT    = 10;
   localparam int     QUIET_PHASE     = 3;
   localparam longint UNIT            = longint'(1) << FRAC_BITS;
   localparam longint LIMIT_HIGH      = VALUE_MAX;
   localparam longint LIMIT_LOW       = VALUE_MIN;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  =
      CSR_INDEX_WIDTH'(CSR_FIRST_STEP_MODE + 1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = '1;

   class momentum_scoreboard;
      typedef struct packed {
         value_type weight;
         value_type velocity;
      } update_type;

      update_type  pending_updates[$];
      coef_type    learn_rate = '0;
      coef_type    momentum   = '0;
      coef_type    decay      = '0;
      coef_type    damping    = '0;
      logic        first_step = 1'b0;
      int unsigned failures        = 0;
      int unsigned words_noted     = 0;
      int unsigned results_checked = 0;

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] index, coef_type data);
         case (index)
            CSR_LEARNING_RATE:   learn_rate = data;
            CSR_MOMENTUM_FACTOR: momentum   = data;
            CSR_DECAY_FACTOR:    decay      = data;
            CSR_DAMPING_FACTOR:  damping    = data;
            CSR_FIRST_STEP_MODE: first_step = data[0];
            default: ;
         endcase
      endfunction

      function longint clamp(longint x);
         if (x > LIMIT_HIGH) begin
            return LIMIT_HIGH;
         end
         if (x < LIMIT_LOW) begin
            return LIMIT_LOW;
         end
         return x;
      endfunction

      function longint fixed_mul(longint c, longint x);
         return clamp((c * x) >>> FRAC_BITS);
      endfunction

      function void note_word(value_type weight, value_type gradient, value_type velocity_in);
         longint g;
         longint v;
         longint w;
         g = clamp(longint'(gradient) + fixed_mul(longint'(decay), longint'(weight)));
         if (first_step) begin
            v = g;
         end else begin
            v = clamp(fixed_mul(longint'(momentum), longint'(velocity_in))
                      + fixed_mul(UNIT - longint'(damping), g));
         end
         w = clamp(longint'(weight) - fixed_mul(longint'(learn_rate), v));
         pending_updates.push_back('{weight: value_type'(w), velocity: value_type'(v)});
         words_noted++;
      endfunction

      function void check_result(value_type weight, value_type velocity);
         update_type want;
         if (pending_updates.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none, actual weight %0d velocity %0d",
                     $time, weight, velocity);
            return;
         end
         want = pending_updates.pop_front();
         results_checked++;
         if (weight !== want.weight) begin
            failures++;
            $display("%0t: new_weight expected %0d actual %0d", $time, want.weight, weight);
         end
         if (velocity !== want.velocity) begin
            failures++;
            $display("%0t: new_velocity expected %0d actual %0d", $time, want.velocity, velocity);
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       start;
   logic                       busy;
   value_type                  req_weight_value;
   value_type                  req_gradient_value;
   value_type                  req_old_velocity;
   logic                       rsp_valid;
   value_type                  rsp_new_weight;
   value_type                  rsp_new_velocity;
   logic                       csr_write;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   coef_type                   csr_wdata;

   momentum_scoreboard updates;
   int unsigned        settings_applied = 0;
   int unsigned        quiet_cycles     = 0;

   sgd_momentum_update i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_weight_value   (req_weight_value),
      .req_gradient_value (req_gradient_value),
      .req_old_velocity   (req_old_velocity),
      .rsp_valid          (rsp_valid),
      .rsp_new_weight     (rsp_new_weight),
      .rsp_new_velocity   (rsp_new_velocity),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) begin
            updates.write_register(csr_index, csr_wdata);
         end
         if (start && !busy) begin
            updates.note_word(req_weight_value, req_gradient_value, req_old_velocity);
         end
         if (rsp_valid) begin
            updates.check_result(rsp_new_weight, rsp_new_velocity);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(value_type weight, value_type gradient, value_type velocity_in);
      start              <= 1'b1;
      req_weight_value   <= weight;
      req_gradient_value <= gradient;
      req_old_velocity   <= velocity_in;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_paced(value_type weight, value_type gradient, value_type velocity_in,
                             int idle_percent);
      while ($urandom_range(0, 99) < idle_percent) begin
         start <= 1'b0;
         @(posedge clock);
      end
      send_word(weight, gradient, velocity_in);
   endtask

   task automatic drain_updates();
      start <= 1'b0;
      do @(posedge clock); while (updates.pending_updates.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index, coef_type data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(coef_type rate, coef_type mom, coef_type decay,
                                 coef_type damp, coef_type mode_word, bit spare_write);
      write_csr(CSR_LEARNING_RATE, rate);
      write_csr(CSR_MOMENTUM_FACTOR, mom);
      write_csr(CSR_DECAY_FACTOR, decay);
      write_csr(CSR_DAMPING_FACTOR, damp);
      write_csr(CSR_FIRST_STEP_MODE, mode_word);
      if (spare_write) begin
         write_csr(CSR_INDEX_WIDTH'($urandom_range(CSR_SPARE_HIGH, CSR_SPARE_LOW)),
                   coef_type'($urandom));
      end
      csr_write <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   function automatic coef_type pick_coef();
      case ($urandom_range(0, 6))
         0:       return '0;
         1:       return coef_type'(UNIT);
         2:       return '1;
         3:       return coef_type'($urandom_range(0, 4096));
         4:       return coef_type'($urandom);
         default: return coef_type'($urandom_range(0, 32'(UNIT)));
      endcase
   endfunction

   function automatic value_type pick_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2:       return value_type'(int'($urandom_range(0, 4)) - 2);
         3, 4, 5: return value_type'($urandom);
         default: return value_type'(int'($urandom_range(0, 2097151)) - 1048576);
      endcase
   endfunction

   initial begin
      coef_type mode_word;
      int       idle_percent;
      updates            = new();
      reset              <= 1'b1;
      start              <= 1'b0;
      req_weight_value   <= '0;
      req_gradient_value <= '0;
      req_old_velocity   <= '0;
      csr_write          <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_word(VALUE_MAX, VALUE_MAX, VALUE_MAX);
      send_word(VALUE_MIN, VALUE_MIN, VALUE_MIN);
      send_word(0, 0, 0);
      send_word(-1, 1, -1);

      drain_updates();
      apply_settings(17'd65536, 17'd65536, 17'd65536, 17'd0, 17'd0, 1'b0);
      send_word(VALUE_MAX, VALUE_MAX, VALUE_MAX);
      send_word(VALUE_MIN, VALUE_MIN, VALUE_MIN);
      send_word(VALUE_MIN, VALUE_MAX, 0);
      send_word(32'sd65536, -32'sd65536, 32'sd65536);

      drain_updates();
      apply_settings(17'd32768, 17'h1ffff, 17'd6554, 17'd0, 17'h1ffff, 1'b0);
      send_word(32'sh0003_0000, 32'sh0000_8000, VALUE_MAX);
      send_word(32'sh0003_0000, 32'sh0000_8000, VALUE_MIN);
      send_word(VALUE_MIN, VALUE_MIN, 0);
      send_word(VALUE_MAX, -1, 0);

      drain_updates();
      apply_settings(17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1fffe, 1'b0);
      send_word(VALUE_MAX, VALUE_MAX, VALUE_MIN);
      send_word(VALUE_MIN, VALUE_MIN, VALUE_MAX);
      send_word(-1, -1, -1);
      send_word(32'sh0001_8000, -32'sh0002_0000, 32'sh7000_0000);

      drain_updates();
      apply_settings(17'd655, 17'd58982, 17'd0, 17'd98304, 17'd0, 1'b1);
      send_word(32'sh0010_0000, 32'sh0000_4000, -32'sh0000_2000);
      send_word(VALUE_MAX, VALUE_MIN, VALUE_MAX);
      send_word(VALUE_MIN, VALUE_MAX, VALUE_MIN);
      send_word(32'sh0000_0001, -32'sh0000_0001, 32'sh0000_0001);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_updates();
         mode_word    = coef_type'($urandom);
         mode_word[0] = ($urandom_range(0, 3) == 0);
         apply_settings(pick_coef(), pick_coef(), pick_coef(), pick_coef(), mode_word,
                        $urandom_range(0, 1));
         idle_percent = (phase == QUIET_PHASE) ? 0 : IDLE_PERCENT;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            send_paced(pick_value(), pick_value(), pick_value(), idle_percent);
         end
      end

      drain_updates();
      repeat (PIPE_DEPTH + 4) @(posedge clock);

      $display("Checked %0d updates from %0d words under %0d coefficient settings,",
               updates.results_checked, updates.words_noted, settings_applied);
      $display("covering saturation, first-step mode, oversized coefficients and spare writes.");
      if (updates.failures == 0 && updates.pending_updates.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/sgdm_pkg.sv
src/sgd_momentum_update.sv
sim/tb_sgd_momentum_update.sv
